[rtl/vsd_pkg.sv]
// vsd_pkg: shared widths, codes, register indexes and controller/datapath structs
// for the snorm16 vertex dequantizer; no dependencies
package vsd_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int NUM_AXES   = 3;
   localparam int KIND_W     = 3;
   localparam int RAW_W      = 16;
   localparam int VAL_W      = 32;
   localparam int SUM_W      = 34;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 224;
   localparam int RSP_USER_W = 4;

   localparam logic [KIND_W-1:0] KIND_POS_X = 3'd0;
   localparam logic [KIND_W-1:0] KIND_POS_Y = 3'd1;
   localparam logic [KIND_W-1:0] KIND_POS_Z = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TEX_U = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TEX_V = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_POS_SCALE_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_POS_SCALE_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_POS_SCALE_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_POS_OFFSET_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POS_OFFSET_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_POS_OFFSET_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TEX_SCALE    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_TEX_OFFSET   = 3'd7;

   // snorm normalization: positive values divide by 2^15 - 1, negative by 2^15
   localparam int NORM_SHIFT    = 15;
   localparam int NORM_DEN_POS  = 32767;
   localparam int NORM_HALF_POS = 16383;
   localparam int NORM_HALF_NEG = 16384;

   // centimeter to meter step for unskinned positions: shift by 2, then divide
   // by 25 through a multiply by ceil(2^35 / 25)
   localparam int DIV_HALF        = 50;
   localparam int DIV_PRESHIFT    = 2;
   localparam int DIV_RECIP_W     = 31;
   localparam int DIV_RECIP_SHIFT = 35;
   localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 31'd1374389535;

   localparam logic signed [VAL_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VAL_W-1:0] SAT_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [NUM_AXES-1:0][VAL_W-1:0] pos_scale;
      logic [NUM_AXES-1:0][VAL_W-1:0] pos_offset;
      logic [CSR_DATA_W-1:0]          tex_scale;
      logic [CSR_DATA_W-1:0]          tex_offset;
   } csr_type;

   typedef struct packed {
      logic capture;
      logic norm_en;
      logic mul_en;
      logic add_en;
      logic div_start;
      logic div_wb;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic needs_div;
      logic div_busy;
   } status_type;

endpackage

[rtl/vsd_csr.sv]
// vsd_csr: configuration register file (position and texture scale/offset)
// depends on vsd_pkg
module vsd_csr import vsd_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output csr_type               csr_o
);

   localparam logic [VAL_W-1:0] ONE = VAL_W'(1) << FRAC_BITS;

   csr_type csr_ff;
   csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_POS_SCALE_X:  csr_in.pos_scale[0]  = csr_wdata[VAL_W-1:0];
            REG_POS_SCALE_Y:  csr_in.pos_scale[1]  = csr_wdata[VAL_W-1:0];
            REG_POS_SCALE_Z:  csr_in.pos_scale[2]  = csr_wdata[VAL_W-1:0];
            REG_POS_OFFSET_X: csr_in.pos_offset[0] = csr_wdata[VAL_W-1:0];
            REG_POS_OFFSET_Y: csr_in.pos_offset[1] = csr_wdata[VAL_W-1:0];
            REG_POS_OFFSET_Z: csr_in.pos_offset[2] = csr_wdata[VAL_W-1:0];
            REG_TEX_SCALE:    csr_in.tex_scale     = csr_wdata;
            REG_TEX_OFFSET:   csr_in.tex_offset    = csr_wdata;
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.pos_scale  <= {ONE, ONE, ONE};
         csr_ff.pos_offset <= '0;
         csr_ff.tex_scale  <= {ONE, ONE};
         csr_ff.tex_offset <= '0;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr_o = csr_ff;

endmodule

[rtl/vsd_div100.sv]
// vsd_div100: divide by the constant 100 as a shift by two and a reciprocal
// multiply for the division by 25; the shifted dividend and then the product are registered; depends on vsd_pkg
module vsd_div100 import vsd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   output logic             busy,
   output logic [SUM_W-1:0] quotient
);

   localparam int Y_W    = SUM_W - DIV_PRESHIFT;
   localparam int PROD_W = Y_W + DIV_RECIP_W;

   logic              stage_ff, stage_in;
   logic [Y_W-1:0]    y_ff, y_in;
   logic [PROD_W-1:0] prod_ff, prod_in;

   assign busy = stage_ff;

   // exact for any y below 2^32: the reciprocal error stays under one part in 25
   assign stage_in = start;
   assign y_in     = start ? dividend[SUM_W-1:DIV_PRESHIFT] : y_ff;
   assign prod_in  = stage_ff ? (PROD_W'(y_ff) * PROD_W'(DIV_RECIP)) : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      prod_ff <= prod_in;
   end

   assign quotient = SUM_W'(prod_ff[PROD_W-1:DIV_RECIP_SHIFT]);

endmodule

[rtl/vsd_datapath.sv]
// vsd_datapath: normalize, scale multiply, round and offset, divide by 100,
// saturate, bound tracking and result register; depends on vsd_pkg, vsd_div100
module vsd_datapath import vsd_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  csr_type               csr_i,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [REQ_USER_W-1:0] req_tuser,
   input  logic                  req_tlast,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   localparam int MAG_W = RAW_W + 1;
   localparam int NUM_W = FRAC_BITS + MAG_W;
   localparam int AW    = FRAC_BITS + 3;
   localparam int QW    = FRAC_BITS + 2;
   localparam int PW    = FRAC_BITS + VAL_W + 2;
   localparam int BND_W = 2 * NUM_AXES * VAL_W;

   // captured transaction
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [RAW_W-1:0]  raw_ff, raw_in;
   logic              bones_ff, bones_in;
   logic              eom_ff, eom_in;

   logic signed [QW-1:0]    n_ff, n_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [SUM_W-1:0] s_ff, s_in;

   logic signed [VAL_W-1:0] min_ff [NUM_AXES];
   logic signed [VAL_W-1:0] max_ff [NUM_AXES];
   logic signed [VAL_W-1:0] min_in [NUM_AXES];
   logic signed [VAL_W-1:0] max_in [NUM_AXES];
   logic signed [VAL_W-1:0] min_upd [NUM_AXES];
   logic signed [VAL_W-1:0] max_upd [NUM_AXES];

   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   // normalization
   logic             neg;
   logic [MAG_W-1:0] raw_ext;
   logic [MAG_W-1:0] mag;
   logic [NUM_W-1:0] num;
   logic [AW-1:0]    a, ab, a2, sum2, q;
   logic             corr;

   // scaling
   logic             is_pos, is_tex;
   logic signed [VAL_W-1:0] scale_sel, off_sel;
   logic             pneg;
   logic [PW-1:0]    pmag, pround;
   logic [VAL_W-1:0] tmag;
   logic signed [VAL_W:0]   t;
   logic signed [SUM_W-1:0] s_scaled;

   // divide and saturate
   logic [SUM_W-1:0] s_mag;
   logic [SUM_W-1:0] div_dividend;
   logic [SUM_W-1:0] quot;
   logic             div_busy;
   logic signed [VAL_W-1:0] val_sat;
   logic [BND_W-1:0] bnd_blk;

   assign kind_in  = cmd.capture ? req_tuser[KIND_W-1:0] : kind_ff;
   assign bones_in = cmd.capture ? req_tuser[KIND_W]     : bones_ff;
   assign raw_in   = cmd.capture ? req_tdata             : raw_ff;
   assign eom_in   = cmd.capture ? req_tlast             : eom_ff;

   // round(|raw| * 2^F / den); division by 2^15 - 1 folds the high part back twice
   always_comb begin
      neg     = raw_ff[RAW_W-1];
      raw_ext = {raw_ff[RAW_W-1], raw_ff};
      mag     = neg ? (~raw_ext + 1'b1) : raw_ext;
      num     = {mag, {FRAC_BITS{1'b0}}}
                + NUM_W'(neg ? NORM_HALF_NEG : NORM_HALF_POS);
      a       = AW'(num >> NORM_SHIFT);
      ab      = a + AW'(num[NORM_SHIFT-1:0]);
      a2      = ab >> NORM_SHIFT;
      sum2    = a2 + AW'(ab[NORM_SHIFT-1:0]);
      corr    = (sum2 >= AW'(NORM_DEN_POS));
      q       = neg ? a : (a + a2 + AW'(corr));
      n_in    = cmd.norm_en ? QW'(neg ? (~q + 1'b1) : q) : n_ff;
   end

   assign is_pos = (kind_ff <= KIND_POS_Z);
   assign is_tex = (kind_ff == KIND_TEX_U) || (kind_ff == KIND_TEX_V);

   always_comb begin
      case (kind_ff)
         KIND_POS_X: begin
            scale_sel = csr_i.pos_scale[0];
            off_sel   = csr_i.pos_offset[0];
         end
         KIND_POS_Y: begin
            scale_sel = csr_i.pos_scale[1];
            off_sel   = csr_i.pos_offset[1];
         end
         KIND_POS_Z: begin
            scale_sel = csr_i.pos_scale[2];
            off_sel   = csr_i.pos_offset[2];
         end
         KIND_TEX_U: begin
            scale_sel = csr_i.tex_scale[VAL_W-1:0];
            off_sel   = csr_i.tex_offset[VAL_W-1:0];
         end
         KIND_TEX_V: begin
            scale_sel = csr_i.tex_scale[CSR_DATA_W-1:VAL_W];
            off_sel   = csr_i.tex_offset[CSR_DATA_W-1:VAL_W];
         end
         default: begin
            scale_sel = csr_i.pos_scale[0];
            off_sel   = csr_i.pos_offset[0];
         end
      endcase
   end

   assign prod_in = cmd.mul_en ? (PW'(n_ff) * PW'(scale_sel)) : prod_ff;

   // product / 2^F rounded half away from zero, then offset added
   always_comb begin
      pneg     = prod_ff[PW-1];
      pmag     = pneg ? (~prod_ff + 1'b1) : prod_ff;
      pround   = pmag + (PW'(1) << (FRAC_BITS - 1));
      tmag     = VAL_W'(pround >> FRAC_BITS);
      t        = pneg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
      s_scaled = SUM_W'(t) + SUM_W'(off_sel);
   end

   assign s_mag        = s_ff[SUM_W-1] ? (~s_ff + 1'b1) : s_ff;
   assign div_dividend = s_mag + SUM_W'(DIV_HALF);

   always_comb begin
      s_in = s_ff;
      if (cmd.add_en) begin
         s_in = (is_pos || is_tex) ? s_scaled : SUM_W'(n_ff);
      end else if (cmd.div_wb) begin
         s_in = s_ff[SUM_W-1] ? (~quot + 1'b1) : quot;
      end
   end

   vsd_div100 u_div100 (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .busy     (div_busy),
      .quotient (quot)
   );

   assign status.needs_div = is_pos && !bones_ff;
   assign status.div_busy  = div_busy;

   always_comb begin
      if (s_ff > SUM_W'(SAT_MAX)) begin
         val_sat = SAT_MAX;
      end else if (s_ff < SUM_W'(SAT_MIN)) begin
         val_sat = SAT_MIN;
      end else begin
         val_sat = s_ff[VAL_W-1:0];
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         min_upd[i] = (is_pos && kind_ff == KIND_W'(i) && val_sat < min_ff[i])
                      ? val_sat : min_ff[i];
         max_upd[i] = (is_pos && kind_ff == KIND_W'(i) && val_sat > max_ff[i])
                      ? val_sat : max_ff[i];
         if (cmd.out_load) begin
            min_in[i] = eom_ff ? SAT_MAX : min_upd[i];
            max_in[i] = eom_ff ? SAT_MIN : max_upd[i];
         end else begin
            min_in[i] = min_ff[i];
            max_in[i] = max_ff[i];
         end
      end
   end

   // bounds leave only with the end-of-mesh result and include its component
   assign bnd_blk = eom_ff ? {max_upd[2], max_upd[1], max_upd[0],
                              min_upd[2], min_upd[1], min_upd[0]} : '0;

   assign rsp_data_in = cmd.out_load ? {bnd_blk, val_sat}  : rsp_data_ff;
   assign rsp_user_in = cmd.out_load ? {eom_ff, kind_ff}   : rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            min_ff[i] <= SAT_MAX;
            max_ff[i] <= SAT_MIN;
         end
      end else begin
         for (int i = 0; i < NUM_AXES; i++) begin
            min_ff[i] <= min_in[i];
            max_ff[i] <= max_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      raw_ff      <= raw_in;
      bones_ff    <= bones_in;
      eom_ff      <= eom_in;
      n_ff        <= n_in;
      prod_ff     <= prod_in;
      s_ff        <= s_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

[rtl/vsd_ctrl.sv]
// vsd_ctrl: sequencing state machine and result-valid flag for the dequantizer
// depends on vsd_pkg
module vsd_ctrl import vsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_NORM     = 7'b0000010,
      S_MUL      = 7'b0000100,
      S_ADD      = 7'b0001000,
      S_DIVSTART = 7'b0010000,
      S_DIV      = 7'b0100000,
      S_DONE     = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign out_free   = !out_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) state_in = S_NORM;
         end
         S_NORM: begin
            cmd.norm_en = 1'b1;
            state_in    = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = S_ADD;
         end
         S_ADD: begin
            cmd.add_en = 1'b1;
            state_in   = status.needs_div ? S_DIVSTART : S_DONE;
         end
         S_DIVSTART: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (!status.div_busy) begin
               cmd.div_wb = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            // result register may still hold the previous transaction
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign out_valid_in = cmd.out_load ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;

endmodule

[rtl/vertex_snorm16_dequantizer_core.sv]
// vertex_snorm16_dequantizer_core: a transaction accepted in idle passes through the
// normalize, multiply, round/offset and output steps before rsp_tvalid, and the next one
// is accepted only after the output step. unskinned positions add a divide-by-100 step
// (start, then wait for the divider); rsp_tready low stretches the output step.
// a pending result does not block acceptance of the next transaction.
// synchronous active-high reset: registers to 1.0 scale / 0 offset, bounds cleared.
module vertex_snorm16_dequantizer_core import vsd_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // raw_value
   input  logic [REQ_USER_W-1:0] req_tuser,  // component_kind, has_bones
   input  logic                  req_tlast,  // end_of_mesh
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_value, bound_min_x, bound_min_y, bound_min_z,
   // bound_max_x, bound_max_y, bound_max_z
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser   // result_kind, bounds_valid
);

   csr_type    csr;
   cmd_type    cmd;
   status_type status;

   vsd_csr #(
      .FRAC_BITS (FRAC_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_o     (csr)
   );

   vsd_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_i     (csr),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   vsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

endmodule
